/* hdl/stmf_pkg.sv */
`timescale 1ns / 1ps

package stmf_pkg;

    localparam int STMF_MAX_WINDOW = 16;
    localparam int SAMPLE_W        = 16;
    localparam int COUNT_W         = 5;

    localparam logic [COUNT_W-1:0] WSIZE_RESET = 5'd16;
    localparam logic [COUNT_W-1:0] TRIM_ABOVE  = 5'd3;
    localparam logic [COUNT_W-1:0] TRIM_DROP   = 5'd2;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;

    localparam logic KIND_PUSH  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] sample;
    } req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic [COUNT_W-1:0]         count;
    } rsp_t;

    // control part of the reduction token that walks down the cell chain
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] left;
    } tok_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INJECT,
        ST_SCAN,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

/* hdl/sliding_trimmed_mean_filter.sv */
`timescale 1ns / 1ps

// channel  | handshake               | payload
// ---------+-------------------------+-----------------------------------
// req      | req_valid / req_stall   | req_t : kind, sample
// rsp      | rsp_valid / rsp_stall   | rsp_t : average, count
// cfg      | cfg_valid / cfg_ready   | cfg_data : window_size
//
// Push item: from acceptance the item passes the inject state, the token walking the
// cell chain and the bit-serial divider before the result loads into the rsp register.
// Clear item: goes straight from idle to the done state. The next item can be accepted
// in the cycle after the result loads. One item in flight; the rsp register lets the next
// item start while a result waits. Reset empties the window, window_size 16.
// req_stall is high from acceptance until the result is in the rsp register.

module sliding_trimmed_mean_filter import stmf_pkg::*; #(
    parameter int MAX_WINDOW = STMF_MAX_WINDOW
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  req_t               req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_t               rsp,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data
);

    localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int NUM_W = SUM_W + 2;

    state_t                     state_reg;
    state_t                     state_next;
    logic [COUNT_W-1:0]         ws_reg;
    logic [COUNT_W-1:0]         ws_next;
    logic [COUNT_W-1:0]         fill_reg;
    logic [COUNT_W-1:0]         fill_next;
    logic signed [SAMPLE_W-1:0] avg_reg;
    logic signed [SAMPLE_W-1:0] avg_next;
    logic                       rsp_valid_reg;
    logic                       rsp_valid_next;
    rsp_t                       rsp_reg;
    rsp_t                       rsp_next;

    logic                       req_take;
    logic                       is_clear;
    logic                       shift;
    logic                       inject;
    logic                       div_start;
    logic                       rsp_load;
    logic                       rsp_free;
    logic [COUNT_W-1:0]         eff_size;
    logic [COUNT_W:0]           fill_inc;
    logic                       trim;
    logic signed [NUM_W-1:0]    num;
    logic [COUNT_W-1:0]         den;
    logic                       div_done;
    logic signed [SAMPLE_W-1:0] div_quo;

    logic signed [SAMPLE_W-1:0] smp_chain [MAX_WINDOW+1];
    tok_ctl_t                   tok_chain [MAX_WINDOW+1];
    logic signed [SUM_W-1:0]    sum_chain [MAX_WINDOW+1];
    logic signed [SAMPLE_W-1:0] hi_chain  [MAX_WINDOW+1];
    logic signed [SAMPLE_W-1:0] lo_chain  [MAX_WINDOW+1];

    assign req_take  = req_valid && !req_stall;
    assign is_clear  = req.kind == KIND_CLEAR;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign cfg_ready = 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    state_next = is_clear ? ST_DONE : ST_INJECT;
                end
            end
            ST_INJECT:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (tok_chain[MAX_WINDOW].valid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        req_stall = 1'b1;
        shift     = 1'b0;
        inject    = 1'b0;
        div_start = 1'b0;
        rsp_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                shift     = req_valid && !is_clear;
            end
            ST_INJECT:
            begin
                inject = 1'b1;
            end
            ST_SCAN:
            begin
                div_start = tok_chain[MAX_WINDOW].valid;
            end
            ST_DIV:
            begin
            end
            ST_DONE:
            begin
                rsp_load = rsp_free;
            end
            default:
            begin
            end
        endcase
    end

    // window_size 0 acts as 1, above the cell count it saturates
    always_comb
    begin
        if (ws_reg == '0)
        begin
            eff_size = COUNT_W'(1);
        end
        else if (int'(ws_reg) > MAX_WINDOW)
        begin
            eff_size = COUNT_W'(MAX_WINDOW);
        end
        else
        begin
            eff_size = ws_reg;
        end
    end

    assign fill_inc = {1'b0, fill_reg} + 1'b1;

    always_comb
    begin
        ws_next   = (cfg_valid && cfg_ready) ? cfg_data : ws_reg;
        fill_next = fill_reg;
        avg_next  = avg_reg;
        if (req_take)
        begin
            if (is_clear)
            begin
                fill_next = '0;
                avg_next  = '0;
            end
            else
            begin
                fill_next = (fill_inc > {1'b0, eff_size}) ? eff_size
                                                          : fill_inc[COUNT_W-1:0];
            end
        end
        else if (div_done)
        begin
            avg_next = div_quo;
        end
    end

    // trimmed numerator and divisor from the token leaving the last cell
    assign trim = fill_reg > TRIM_ABOVE;
    assign num  = trim ? NUM_W'(sum_chain[MAX_WINDOW]) - NUM_W'(hi_chain[MAX_WINDOW])
                         - NUM_W'(lo_chain[MAX_WINDOW])
                       : NUM_W'(sum_chain[MAX_WINDOW]);
    assign den  = trim ? fill_reg - TRIM_DROP : fill_reg;

    assign smp_chain[0]       = req.sample;
    assign tok_chain[0].valid = inject;
    assign tok_chain[0].left  = fill_reg;
    assign sum_chain[0]       = '0;
    assign hi_chain[0]        = SAMPLE_MIN;
    assign lo_chain[0]        = SAMPLE_MAX;

    for (genvar k = 0; k < MAX_WINDOW; k++)
    begin : g_cell
        stmf_cell #(
            .SUM_W (SUM_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (shift),
            .smp_in  (smp_chain[k]),
            .smp_out (smp_chain[k+1]),
            .tok_in  (tok_chain[k]),
            .sum_in  (sum_chain[k]),
            .hi_in   (hi_chain[k]),
            .lo_in   (lo_chain[k]),
            .tok_out (tok_chain[k+1]),
            .sum_out (sum_chain[k+1]),
            .hi_out  (hi_chain[k+1]),
            .lo_out  (lo_chain[k+1])
        );
    end

    stmf_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        rsp_valid_next = rsp_load || (rsp_valid_reg && rsp_stall);
        rsp_next       = rsp_reg;
        if (rsp_load)
        begin
            rsp_next.average = avg_reg;
            rsp_next.count   = fill_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ws_reg        <= WSIZE_RESET;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ws_reg        <= ws_next;
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg <= avg_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // token must have collected exactly fill_count samples by the chain end
    a_tok_drained: assert property (@(posedge clk) disable iff (!rst_n)
        tok_chain[MAX_WINDOW].valid |-> (tok_chain[MAX_WINDOW].left == '0))
        else $error("token left the chain with samples uncollected");

    a_tok_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tok_chain[MAX_WINDOW].valid |-> (state_reg == ST_SCAN))
        else $error("token reached chain end outside scan");

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide state");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (req_take && is_clear) |=> (fill_reg == '0 && state_reg == ST_DONE))
        else $error("clear item did not empty the window");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_reg) <= MAX_WINDOW)
        else $error("fill count beyond cell count");

endmodule

/* hdl/stmf_cell.sv */
`timescale 1ns / 1ps

module stmf_cell import stmf_pkg::*; #(
    parameter int SUM_W = SAMPLE_W + 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       shift,
    input  logic signed [SAMPLE_W-1:0] smp_in,
    output logic signed [SAMPLE_W-1:0] smp_out,
    input  tok_ctl_t                   tok_in,
    input  logic signed [SUM_W-1:0]    sum_in,
    input  logic signed [SAMPLE_W-1:0] hi_in,
    input  logic signed [SAMPLE_W-1:0] lo_in,
    output tok_ctl_t                   tok_out,
    output logic signed [SUM_W-1:0]    sum_out,
    output logic signed [SAMPLE_W-1:0] hi_out,
    output logic signed [SAMPLE_W-1:0] lo_out
);

    logic signed [SAMPLE_W-1:0] smp_reg;
    logic signed [SAMPLE_W-1:0] smp_next;
    tok_ctl_t                   tok_reg;
    tok_ctl_t                   tok_next;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [SAMPLE_W-1:0] hi_reg;
    logic signed [SAMPLE_W-1:0] hi_next;
    logic signed [SAMPLE_W-1:0] lo_reg;
    logic signed [SAMPLE_W-1:0] lo_next;
    logic                       take;

    assign smp_next = shift ? smp_in : smp_reg;

    // cell takes part while the token still has samples left to collect
    assign take = tok_in.left != '0;

    always_comb
    begin
        tok_next.valid = tok_in.valid;
        tok_next.left  = take ? tok_in.left - 1'b1 : tok_in.left;
        sum_next       = take ? sum_in + SUM_W'(smp_reg) : sum_in;
        hi_next        = (take && (smp_reg > hi_in)) ? smp_reg : hi_in;
        lo_next        = (take && (smp_reg < lo_in)) ? smp_reg : lo_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg <= smp_next;
        sum_reg <= sum_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
    end

    assign smp_out = smp_reg;
    assign tok_out = tok_reg;
    assign sum_out = sum_reg;
    assign hi_out  = hi_reg;
    assign lo_out  = lo_reg;

endmodule

/* hdl/stmf_div.sv */
`timescale 1ns / 1ps

module stmf_div import stmf_pkg::*; #(
    parameter int NUM_W = SAMPLE_W + 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [NUM_W-1:0]    num,
    input  logic [COUNT_W-1:0]         den,
    output logic                       done,
    output logic signed [SAMPLE_W-1:0] quo
);

    localparam int MAG_W = NUM_W - 1;
    localparam int CNT_W = $clog2(MAG_W + 1);

    logic               busy_reg;
    logic               busy_next;
    logic               done_reg;
    logic               done_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [MAG_W-1:0]   mag_reg;
    logic [MAG_W-1:0]   mag_next;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] rem_next;
    logic [COUNT_W-1:0] den_reg;
    logic [COUNT_W-1:0] den_next;
    logic               neg_reg;
    logic               neg_next;
    logic [COUNT_W:0]   rem_sh;
    logic               ge;
    logic [NUM_W-1:0]   num_neg;

    assign num_neg = -num;
    assign rem_sh  = {rem_reg, mag_reg[MAG_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};

    // restoring divide on magnitudes, one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MAG_W);
            mag_next  = num[NUM_W-1] ? num_neg[MAG_W-1:0] : num[MAG_W-1:0];
            rem_next  = '0;
            den_next  = den;
            neg_next  = num[NUM_W-1];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? COUNT_W'(rem_sh - {1'b0, den_reg}) : rem_sh[COUNT_W-1:0];
            mag_next = {mag_reg[MAG_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // quotient magnitude never exceeds 32768, so the low bits carry it
    assign done = done_reg;
    assign quo  = neg_reg ? -mag_reg[SAMPLE_W-1:0] : mag_reg[SAMPLE_W-1:0];

endmodule

/* tb/sv/trimmed_mean_watch.sv */
`timescale 1ns / 1ps

module trimmed_mean_watch import stmf_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_stall,
    input  req_t               req,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  rsp_t               rsp,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data,
    output int                 mismatches,
    output int                 pending
);

    logic signed [SAMPLE_W-1:0] held [STMF_MAX_WINDOW];
    int                         fill;
    logic [COUNT_W-1:0]         span;
    rsp_t                       mean_due [$];
    rsp_t                       due;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // shift the sample in (or empty the window) and work out the mean that follows
    function automatic rsp_t advance_window(input req_t item);
        rsp_t r;
        int   lim;
        int   total;
        int   hi;
        int   lo;
        int   mean;
        mean = 0;
        if (item.kind == KIND_CLEAR)
        begin
            fill = 0;
        end
        else
        begin
            for (int k = STMF_MAX_WINDOW - 1; k > 0; k--)
                held[k] = held[k-1];
            held[0] = item.sample;
            // zero acts as one, oversize saturates
            if (span == 0)
                lim = 1;
            else if (int'(span) > STMF_MAX_WINDOW)
                lim = STMF_MAX_WINDOW;
            else
                lim = int'(span);
            fill = (fill + 1 > lim) ? lim : fill + 1;
            total = 0;
            hi = held[0];
            lo = held[0];
            for (int k = 0; k < fill; k++)
            begin
                if (held[k] > hi)
                    hi = held[k];
                if (held[k] < lo)
                    lo = held[k];
                total += held[k];
            end
            // SV signed division truncates toward zero
            if (fill > int'(TRIM_ABOVE))
                mean = (total - hi - lo) / (fill - int'(TRIM_DROP));
            else
                mean = total / fill;
        end
        r.average = mean[SAMPLE_W-1:0];
        r.count   = fill[COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill = 0;
            span = WSIZE_RESET;
            mean_due.delete();
            for (int k = 0; k < STMF_MAX_WINDOW; k++)
                held[k] = '0;
            pending = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (mean_due.size() == 0)
                    report_mismatch($sformatf("unexpected result: average %0d count %0d",
                                              rsp.average, rsp.count));
                else
                begin
                    due = mean_due.pop_front();
                    if (rsp.average !== due.average)
                        report_mismatch($sformatf("average got %0d expected %0d",
                                                  rsp.average, due.average));
                    if (rsp.count !== due.count)
                        report_mismatch($sformatf("count got %0d expected %0d",
                                                  rsp.count, due.count));
                end
            end
            if (cfg_valid && cfg_ready)
                span = cfg_data;
            if (req_valid && !req_stall)
                mean_due.push_back(advance_window(req));
            pending = mean_due.size();
        end
    end

endmodule

/* tb/sv/sliding_trimmed_mean_filter_test.sv */
`timescale 1ns / 1ps

module sliding_trimmed_mean_filter_test;
    import stmf_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 120;
    localparam int TAIL_CYCLES  = 60;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    req_t               req;
    logic               rsp_valid;
    logic               rsp_stall;
    rsp_t               rsp;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data;

    int mismatches;
    int pending;
    int req_idle_pct;
    int rsp_idle_pct;
    int stall_left;
    int quiet;

    logic [COUNT_W-1:0] phase_span [PHASES] =
        '{5'd16, 5'd1, 5'd4, 5'd3, 5'd0, 5'd31, 5'd17, 5'd2, 5'd5, 5'd8, 5'd16, 5'd16};

    sliding_trimmed_mean_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    trimmed_mean_watch i_watch (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #10 clk = ~clk;

    // result-side backpressure in bursts of random length
    always @(negedge clk)
    begin
        if (stall_left == 0 && rsp_idle_pct != 0 && $urandom_range(1, 100) <= rsp_idle_pct)
            stall_left = $urandom_range(1, 8);
        rsp_stall <= (stall_left > 0);
        if (stall_left > 0)
            stall_left--;
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("sliding_trimmed_mean_filter regression: fail");
                $finish;
            end
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int v;
        case ($urandom_range(0, 7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2, 3, 4:
            begin
                // narrow range so ties and repeated extremes show up in the window
                v = $urandom_range(0, 40);
                return 16'(v - 20);
            end
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_item(input logic op, input logic signed [SAMPLE_W-1:0] value);
        req_t item;
        int   gap;
        item.kind   = op;
        item.sample = value;
        @(negedge clk);
        if (req_idle_pct != 0 && $urandom_range(1, 100) <= req_idle_pct)
        begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (req_stall);
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // window size only changes with the filter idle
    task automatic set_window(input logic [COUNT_W-1:0] n);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int clear_pct;
        clk          = 1'b0;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        rsp_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        stall_left   = 0;
        quiet        = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        req_idle_pct = 25;
        rsp_idle_pct = 25;
        // plain mean up to three samples, trimmed from the fourth
        send_item(KIND_PUSH, SAMPLE_MAX);
        send_item(KIND_PUSH, SAMPLE_MIN);
        send_item(KIND_PUSH, 16'sd0);
        send_item(KIND_PUSH, -16'sd1);
        send_item(KIND_PUSH, 16'sd1);
        send_item(KIND_PUSH, SAMPLE_MAX);
        send_item(KIND_PUSH, SAMPLE_MAX);
        send_item(KIND_CLEAR, SAMPLE_MIN);
        send_item(KIND_CLEAR, 16'sd0);
        // negative odd sums check truncation toward zero
        send_item(KIND_PUSH, -16'sd7);
        send_item(KIND_PUSH, 16'sd2);
        send_item(KIND_PUSH, 16'sd3);
        send_item(KIND_PUSH, 16'sd3);
        // shrink below the fill level
        set_window(5'd2);
        send_item(KIND_PUSH, 16'sd5);
        set_window(5'd0);
        send_item(KIND_PUSH, 16'sd9);
        send_item(KIND_PUSH, -16'sd9);
        set_window(5'd31);
        send_item(KIND_PUSH, SAMPLE_MIN);
        send_item(KIND_PUSH, SAMPLE_MIN);
        send_item(KIND_PUSH, SAMPLE_MAX);
        send_item(KIND_PUSH, SAMPLE_MIN);
        send_item(KIND_CLEAR, SAMPLE_MAX);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == PHASES - 2)
                set_window(5'($urandom_range(0, 31)));
            else
                set_window(phase_span[ph]);
            if (ph == PHASES - 1)
            begin
                req_idle_pct = 0;
                rsp_idle_pct = 0;
            end
            else
            begin
                req_idle_pct = (ph % 3) * 25;
                rsp_idle_pct = ((ph + 1) % 3) * 25;
            end
            clear_pct = $urandom_range(1, 8);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(1, 100) <= clear_pct)
                    send_item(KIND_CLEAR, 16'($urandom()));
                else
                    send_item(KIND_PUSH, pick_sample());
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("sliding_trimmed_mean_filter regression: pass");
        else
            $display("sliding_trimmed_mean_filter regression: fail");
        $finish;
    end

endmodule
